>>> hdl/assert_macros.svh
// assertion macros used by the top level of the rmc sentence parser
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NRMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NRMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/nrmc_pkg.sv
// shared types, character codes and constants of the rmc sentence parser
// no dependencies; the interface and module files refer to it by scoped names
package nrmc_pkg;

  localparam int MAX_DIGITS = 12;
  localparam int MANT_W     = 40;
  localparam int BCD_W      = 24;

  // largest mantissa: the smaller of 10^MAX_DIGITS - 1 and 2^40 - 1
  function automatic logic [MANT_W-1:0] mant_limit();
    longint unsigned p;
    logic [MANT_W-1:0] res;
    p   = 1;
    res = '1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      p = p * 10;
      if (p > (64'd1 << MANT_W)) begin
        return res;
      end
    end
    res = MANT_W'(p - 1);
    return res;
  endfunction

  localparam logic [MANT_W-1:0] MANT_LIMIT = mant_limit();

  // parser phases
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_FIELDS = 2'd2;

  localparam logic [2:0] HDR_LAST = 3'd5;

  // characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  // rmc field indices
  localparam logic [3:0] FLD_NONE    = 4'd0;
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_STATUS  = 4'd2;
  localparam logic [3:0] FLD_LAT     = 4'd3;
  localparam logic [3:0] FLD_LAT_HEM = 4'd4;
  localparam logic [3:0] FLD_LON     = 4'd5;
  localparam logic [3:0] FLD_LON_HEM = 4'd6;
  localparam logic [3:0] FLD_SPEED   = 4'd7;
  localparam logic [3:0] FLD_COURSE  = 4'd8;
  localparam logic [3:0] FLD_DATE    = 4'd9;
  localparam logic [3:0] FLD_MAGVAR  = 4'd10;
  localparam logic [3:0] FLD_VAR_DIR = 4'd11;
  localparam logic [3:0] FLD_MODE    = 4'd12;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // record as closed by the front
  typedef struct packed {
    logic [3:0]        field_number;
    logic [3:0]        char_count;
    logic [MANT_W-1:0] mantissa;
    logic [3:0]        frac_digits;
    logic              digit_overflow;
    logic [7:0]        lead_char;
    logic [BCD_W-1:0]  date_bcd;
    logic              last;
  } raw_rec_t;

  // finished record
  typedef struct packed {
    logic [3:0]        field_number;
    logic              present;
    logic [3:0]        char_count;
    logic [MANT_W-1:0] mantissa;
    logic [3:0]        frac_digits;
    logic              digit_overflow;
    logic [7:0]        lead_char;
    logic [6:0]        date_day;
    logic [6:0]        date_month;
    logic [6:0]        date_year;
    logic              last;
  } out_rec_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] field;
  } front_stat_t;

  function automatic logic field_present(logic [3:0] f, logic [3:0] len);
    logic pr;
    case (f)
      FLD_TIME:                   pr = (len > 4'd7);
      FLD_LAT, FLD_LON:           pr = (len > 4'd6);
      FLD_SPEED, FLD_COURSE:      pr = (len > 4'd2);
      FLD_DATE:                   pr = (len == 4'd6);
      FLD_MAGVAR:                 pr = (len == 4'd2);
      FLD_STATUS, FLD_LAT_HEM,
      FLD_LON_HEM, FLD_VAR_DIR:   pr = (len == 4'd1);
      default:                    pr = 1'b1;
    endcase
    return pr;
  endfunction

endpackage

>>> hdl/nrmc_intf.sv
// request channels of the rmc sentence parser: characters in, field records out
// depends on nrmc_pkg for the mantissa width
interface nrmc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface nrmc_rec_if;
  logic                       valid;
  logic                       ready;
  logic [3:0]                 field_number;
  logic                       present;
  logic [3:0]                 char_count;
  logic [nrmc_pkg::MANT_W-1:0] mantissa;
  logic [3:0]                 frac_digits;
  logic                       digit_overflow;
  logic [7:0]                 lead_char;
  logic [6:0]                 date_day;
  logic [6:0]                 date_month;
  logic [6:0]                 date_year;
  logic                       last;

  modport source (output valid, output field_number, output present, output char_count,
                  output mantissa, output frac_digits, output digit_overflow,
                  output lead_char, output date_day, output date_month,
                  output date_year, output last, input ready);
  modport sink (input valid, input field_number, input present, input char_count,
                input mantissa, input frac_digits, input digit_overflow,
                input lead_char, input date_day, input date_month,
                input date_year, input last, output ready);
endinterface

>>> hdl/nrmc_front.sv
// front of the parser: header hunt, comma split and per-field accumulation
// depends on nrmc_pkg; pushes closed field records towards the queue
module nrmc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  char_valid_i,
  output logic                  char_ready_o,
  input  logic [7:0]            char_i,
  output logic                  rec_valid_o,
  input  logic                  rec_ready_i,
  output nrmc_pkg::raw_rec_t    rec_o,
  output nrmc_pkg::front_stat_t stat_o
);

  localparam int AccW = nrmc_pkg::MANT_W + 4;

  logic [1:0]                  phase_q, phase_d;
  logic [2:0]                  hpos_q, hpos_d;
  logic [3:0]                  field_q, field_d;
  logic [3:0]                  len_q, len_d;
  logic [nrmc_pkg::MANT_W-1:0] acc_q, acc_d;
  logic [3:0]                  frac_q, frac_d;
  logic                        point_q, point_d;
  logic [7:0]                  lead_q, lead_d;
  logic                        ovf_q, ovf_d;
  logic [nrmc_pkg::BCD_W-1:0]  bcd_q, bcd_d;

  logic                        accept;
  logic                        mode_w;
  logic                        is_digit;
  logic [3:0]                  dig;
  logic                        hdr_ok;
  logic                        drop;
  logic [AccW-1:0]             acc_x10;

  // base field state: cleared for the mode character
  logic [3:0]                  b_len, t_len, t_frac, b_frac;
  logic [nrmc_pkg::MANT_W-1:0] b_acc, t_acc;
  logic                        b_point, t_point, b_ovf, t_ovf;
  logic [7:0]                  b_lead, t_lead;
  logic [nrmc_pkg::BCD_W-1:0]  b_bcd, t_bcd;

  assign char_ready_o = rec_ready_i;
  assign accept       = char_valid_i && rec_ready_i;
  assign stat_o.phase = phase_q;
  assign stat_o.field = field_q;

  assign mode_w   = (phase_q == nrmc_pkg::PH_FIELDS) && (field_q >= nrmc_pkg::FLD_MODE);
  assign is_digit = (char_i >= nrmc_pkg::CH_ZERO) && (char_i <= nrmc_pkg::CH_NINE);
  assign dig      = char_i[3:0];

  always_comb begin
    case (hpos_q)
      3'd0:    hdr_ok = (char_i == nrmc_pkg::CH_G);
      3'd1:    hdr_ok = (char_i == nrmc_pkg::CH_P) || (char_i == nrmc_pkg::CH_L) ||
                        (char_i == nrmc_pkg::CH_N);
      3'd2:    hdr_ok = (char_i == nrmc_pkg::CH_R);
      3'd3:    hdr_ok = (char_i == nrmc_pkg::CH_M);
      3'd4:    hdr_ok = (char_i == nrmc_pkg::CH_C);
      3'd5:    hdr_ok = (char_i == nrmc_pkg::CH_COMMA);
      default: hdr_ok = 1'b0;
    endcase
  end

  // take one character into the field state
  always_comb begin
    b_len   = mode_w ? '0 : len_q;
    b_acc   = mode_w ? '0 : acc_q;
    b_frac  = mode_w ? '0 : frac_q;
    b_point = mode_w ? 1'b0 : point_q;
    b_lead  = mode_w ? '0 : lead_q;
    b_ovf   = mode_w ? 1'b0 : ovf_q;
    b_bcd   = mode_w ? '0 : bcd_q;

    // acc * 10 + digit by shift-add
    acc_x10 = {1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0} +
              {{(AccW-4){1'b0}}, dig};
    drop    = (b_point && (b_frac == 4'hF)) ||
              (acc_x10 > {4'b0000, nrmc_pkg::MANT_LIMIT});

    t_lead  = (b_len == 4'd0) ? char_i : b_lead;
    t_len   = (b_len != 4'hF) ? (b_len + 4'd1) : b_len;
    t_acc   = b_acc;
    t_frac  = b_frac;
    t_point = b_point;
    t_ovf   = b_ovf;
    t_bcd   = b_bcd;
    if (is_digit) begin
      if (drop) begin
        t_ovf = 1'b1;
      end else begin
        t_acc = acc_x10[nrmc_pkg::MANT_W-1:0];
        t_bcd = {b_bcd[nrmc_pkg::BCD_W-5:0], dig};
        if (b_point) begin
          t_frac = b_frac + 4'd1;
        end
      end
    end else if (char_i == nrmc_pkg::CH_DOT) begin
      t_point = 1'b1;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    field_d = field_q;
    len_d   = len_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    point_d = point_q;
    lead_d  = lead_q;
    ovf_d   = ovf_q;
    bcd_d   = bcd_q;

    rec_valid_o          = 1'b0;
    rec_o.field_number   = field_q;
    rec_o.char_count     = len_q;
    rec_o.mantissa       = acc_q;
    rec_o.frac_digits    = frac_q;
    rec_o.digit_overflow = ovf_q;
    rec_o.lead_char      = lead_q;
    rec_o.date_bcd       = bcd_q;
    rec_o.last           = 1'b0;

    if (accept) begin
      case (phase_q)
        nrmc_pkg::PH_HEADER: begin
          if (hdr_ok) begin
            if (hpos_q == nrmc_pkg::HDR_LAST) begin
              phase_d = nrmc_pkg::PH_FIELDS;
              field_d = nrmc_pkg::FLD_TIME;
              hpos_d  = '0;
              len_d   = '0;
              acc_d   = '0;
              frac_d  = '0;
              point_d = 1'b0;
              lead_d  = '0;
              ovf_d   = 1'b0;
              bcd_d   = '0;
            end else begin
              hpos_d = hpos_q + 3'd1;
            end
          end else begin
            hpos_d  = '0;
            phase_d = (char_i == nrmc_pkg::CH_DOLLAR) ? nrmc_pkg::PH_HEADER
                                                      : nrmc_pkg::PH_HUNT;
          end
        end
        nrmc_pkg::PH_FIELDS: begin
          if (mode_w) begin
            // any character after the eleventh comma past the header is the mode
            rec_valid_o          = 1'b1;
            rec_o.field_number   = nrmc_pkg::FLD_MODE;
            rec_o.char_count     = t_len;
            rec_o.mantissa       = t_acc;
            rec_o.frac_digits    = t_frac;
            rec_o.digit_overflow = t_ovf;
            rec_o.lead_char      = t_lead;
            rec_o.date_bcd       = t_bcd;
            rec_o.last           = 1'b1;
            phase_d = nrmc_pkg::PH_HUNT;
            field_d = nrmc_pkg::FLD_NONE;
            len_d   = '0;
            acc_d   = '0;
            frac_d  = '0;
            point_d = 1'b0;
            lead_d  = '0;
            ovf_d   = 1'b0;
            bcd_d   = '0;
          end else if ((char_i == nrmc_pkg::CH_DOLLAR) || (char_i == nrmc_pkg::CH_CR) ||
                       (char_i == nrmc_pkg::CH_LF)) begin
            // sentence broken off, no record
            phase_d = (char_i == nrmc_pkg::CH_DOLLAR) ? nrmc_pkg::PH_HEADER
                                                      : nrmc_pkg::PH_HUNT;
            hpos_d  = '0;
            field_d = nrmc_pkg::FLD_NONE;
            len_d   = '0;
            acc_d   = '0;
            frac_d  = '0;
            point_d = 1'b0;
            lead_d  = '0;
            ovf_d   = 1'b0;
            bcd_d   = '0;
          end else if (char_i == nrmc_pkg::CH_COMMA) begin
            rec_valid_o = 1'b1;
            field_d = field_q + 4'd1;
            len_d   = '0;
            acc_d   = '0;
            frac_d  = '0;
            point_d = 1'b0;
            lead_d  = '0;
            ovf_d   = 1'b0;
            bcd_d   = '0;
          end else begin
            len_d   = t_len;
            acc_d   = t_acc;
            frac_d  = t_frac;
            point_d = t_point;
            lead_d  = t_lead;
            ovf_d   = t_ovf;
            bcd_d   = t_bcd;
          end
        end
        default: begin
          hpos_d  = '0;
          phase_d = (char_i == nrmc_pkg::CH_DOLLAR) ? nrmc_pkg::PH_HEADER
                                                    : nrmc_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nrmc_pkg::PH_HUNT;
      hpos_q  <= '0;
      field_q <= nrmc_pkg::FLD_NONE;
      len_q   <= '0;
      acc_q   <= '0;
      frac_q  <= '0;
      point_q <= 1'b0;
      lead_q  <= '0;
      ovf_q   <= 1'b0;
      bcd_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      field_q <= field_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      point_q <= point_d;
      lead_q  <= lead_d;
      ovf_q   <= ovf_d;
      bcd_q   <= bcd_d;
    end
  end

endmodule

>>> hdl/nrmc_queue.sv
// short fifo of closed field records between front and back
// depends on nrmc_pkg for the record type and depth
module nrmc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  nrmc_pkg::raw_rec_t push_rec_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output nrmc_pkg::raw_rec_t pop_rec_o
);

  localparam logic [nrmc_pkg::PTR_W-1:0] LastPtr = nrmc_pkg::PTR_W'(nrmc_pkg::QUEUE_DEPTH - 1);
  localparam logic [nrmc_pkg::CNT_W-1:0] FullCnt = nrmc_pkg::CNT_W'(nrmc_pkg::QUEUE_DEPTH);

  nrmc_pkg::raw_rec_t            entry_q [nrmc_pkg::QUEUE_DEPTH];
  logic [nrmc_pkg::PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [nrmc_pkg::PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [nrmc_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_rec_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

>>> hdl/nrmc_back.sv
// back of the parser: presence rule, ddmmyy split and output register
// depends on nrmc_pkg
module nrmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nrmc_pkg::raw_rec_t in_rec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nrmc_pkg::out_rec_t out_rec_o
);

  // two bcd digits to binary, tens * 10 + units
  function automatic logic [6:0] bcd_pair(logic [7:0] b);
    logic [6:0] tens;
    tens = {3'b000, b[7:4]};
    return (tens << 3) + (tens << 1) + {3'b000, b[3:0]};
  endfunction

  logic               valid_q;
  nrmc_pkg::out_rec_t rec_q, rec_d;
  logic               pres;
  logic               is_date;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;

  always_comb begin
    pres    = nrmc_pkg::field_present(in_rec_i.field_number, in_rec_i.char_count);
    is_date = pres && (in_rec_i.field_number == nrmc_pkg::FLD_DATE);

    rec_d.field_number   = in_rec_i.field_number;
    rec_d.present        = pres;
    rec_d.char_count     = in_rec_i.char_count;
    rec_d.mantissa       = in_rec_i.mantissa;
    rec_d.frac_digits    = in_rec_i.frac_digits;
    rec_d.digit_overflow = in_rec_i.digit_overflow;
    rec_d.lead_char      = in_rec_i.lead_char;
    rec_d.last           = in_rec_i.last;
    // a present date has six characters, so its last six digits are the whole mantissa
    rec_d.date_day   = is_date ? bcd_pair(in_rec_i.date_bcd[23:16]) : '0;
    rec_d.date_month = is_date ? bcd_pair(in_rec_i.date_bcd[15:8])  : '0;
    rec_d.date_year  = is_date ? bcd_pair(in_rec_i.date_bcd[7:0])   : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rec_q <= rec_d;
    end
  end

endmodule

>>> hdl/nmea_rmc_field_extractor_unit.sv
// channel   dir  modport             payload
// char_i    in   nrmc_char_if.sink   char_in, one ascii character
// rec_o     out  nrmc_rec_if.source  one rmc field record
//
// one character is taken every cycle while the queue has room; a record closed
// by a comma or mode character passes the queue stage, then the output register
// reset clears phase, field state, queue pointers and the output valid at once
// a two-entry queue splits front and back; char_i.ready falls only when that
// queue is full, i.e. once three closed fields wait on a stalled record sink
//
// top level of the rmc sentence parser; depends on nrmc_pkg, nrmc_intf,
// nrmc_front, nrmc_queue, nrmc_back and assert_macros.svh
`include "assert_macros.svh"

module nmea_rmc_field_extractor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  nrmc_char_if.sink          char_i,
  nrmc_rec_if.source         rec_o
);

  logic                  fr_valid, fr_ready;
  nrmc_pkg::raw_rec_t    fr_rec;
  nrmc_pkg::front_stat_t fr_stat;
  logic                  bk_valid, bk_ready;
  nrmc_pkg::raw_rec_t    bk_rec;
  logic                  out_valid;
  nrmc_pkg::out_rec_t    out_rec;
  logic                  mode_push;
  logic                  front_idle;
  logic                  mode_shape;
  logic                  other_rec;
  logic                  date_clear;

  nrmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_i.valid),
    .char_ready_o (char_i.ready),
    .char_i       (char_i.char_in),
    .rec_valid_o  (fr_valid),
    .rec_ready_i  (fr_ready),
    .rec_o        (fr_rec),
    .stat_o       (fr_stat)
  );

  nrmc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_rec_i   (fr_rec),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_rec_o    (bk_rec)
  );

  nrmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_rec_i    (bk_rec),
    .out_valid_o (out_valid),
    .out_ready_i (rec_o.ready),
    .out_rec_o   (out_rec)
  );

  assign rec_o.valid          = out_valid;
  assign rec_o.field_number   = out_rec.field_number;
  assign rec_o.present        = out_rec.present;
  assign rec_o.char_count     = out_rec.char_count;
  assign rec_o.mantissa       = out_rec.mantissa;
  assign rec_o.frac_digits    = out_rec.frac_digits;
  assign rec_o.digit_overflow = out_rec.digit_overflow;
  assign rec_o.lead_char      = out_rec.lead_char;
  assign rec_o.date_day       = out_rec.date_day;
  assign rec_o.date_month     = out_rec.date_month;
  assign rec_o.date_year      = out_rec.date_year;
  assign rec_o.last           = out_rec.last;

  assign mode_push  = fr_valid && fr_ready && fr_rec.last;
  assign front_idle = (fr_stat.phase != nrmc_pkg::PH_FIELDS) &&
                      (fr_stat.field == nrmc_pkg::FLD_NONE);
  assign mode_shape = (out_rec.field_number == nrmc_pkg::FLD_MODE) && out_rec.present &&
                      (out_rec.char_count == 4'd1);
  assign other_rec  = out_valid && (out_rec.field_number != nrmc_pkg::FLD_DATE);
  assign date_clear = (out_rec.date_day == '0) && (out_rec.date_month == '0) &&
                      (out_rec.date_year == '0);

  // front only closes a field when the queue has room
  `NRMC_ASSERT_IMP(a_queue_no_overflow, fr_valid, fr_ready, "record pushed into a full queue")

  // the mode record ends the sentence
  `NRMC_ASSERT_NXT(a_mode_ends_sentence, mode_push, front_idle, "sentence open after mode record")

  `NRMC_ASSERT_IMP(a_last_is_mode, out_valid && out_rec.last, mode_shape, "last record not a mode field")

  `NRMC_ASSERT_IMP(a_date_only_field9, other_rec, date_clear, "date split outside the date field")

endmodule
